FILE: hw/rtl/dda_grid_raycaster_top_assert.svh
// assertion macros for the grid raycaster
`ifndef DDA_GRID_RAYCASTER_TOP_ASSERT_SVH
`define DDA_GRID_RAYCASTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DGR_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("dgr check failed");
`define DGR_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("dgr check failed");
`else
`define DGR_ASSERT_IMPL(label, a, c)
`define DGR_ASSERT_NEXT(label, a, c)
`endif
`endif

FILE: hw/rtl/dgr_pkg.sv
// shared types and constants for the grid raycaster
package dgr_pkg;
  localparam logic [7:0] CODE_WALL = 8'h31;
  localparam logic [7:0] CODE_DOOR = 8'h44;
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
  localparam logic [15:0] HEIGHT_MAX = 16'hFFFF;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST = 1'b1;
  // map is square; cell coordinates are 6 bits wide
  localparam int MAP_SIDE = 64;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_RAY   = 11'b00000000010,
    ST_DIVX  = 11'b00000000100,
    ST_DIVY  = 11'b00000001000,
    ST_SIDE  = 11'b00000010000,
    ST_STEP  = 11'b00000100000,
    ST_READ  = 11'b00001000000,
    ST_TEST  = 11'b00010000000,
    ST_LDIV  = 11'b00100000000,
    ST_FIN   = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_t;
endpackage

FILE: hw/rtl/dgr_ram.sv
// generic single-port write, registered read ram
module dgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/dgr_div.sv
// restoring divider, one quotient bit per cycle
module dgr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [33:0] dividend,
  input  logic [23:0] divisor,
  output logic        busy,
  output logic [33:0] quotient
);
  logic [5:0]  cnt_r, cnt_nxt;
  logic [33:0] q_r, q_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [24:0] trial;
  logic [23:0] dvs_r, dvs_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    trial = {rem_r[23:0], q_r[33]};
    if (start) begin
      cnt_nxt = 6'd34;
      q_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != 6'd0) begin
      cnt_nxt = cnt_r - 6'd1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt = {q_r[32:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[32:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = (cnt_r != 6'd0);
  assign quotient = q_r;
endmodule

FILE: hw/rtl/dda_grid_raycaster_top.sv
// grid raycaster top level: map store, dda walk sequencer, result register
// A write item stores a cell in the map. A cast item first runs setup (two 34-step
// reciprocal divisions of the ray components), then walks the grid cell by cell
// (step, map read, test; a step that leaves the map skips the test), then runs the
// slice height division (skipped when the wall distance is zero) and finishes; the
// setup and height divisions share one restoring divider, and the map has a single
// read port. The result waits in an output register; the block takes no item while a
// cast is in flight or unread.
module dda_grid_raycaster_top #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768,
  parameter int MAX_STEPS     = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [5:0]  in_cell_x,
  input  logic [5:0]  in_cell_y,
  input  logic [7:0]  in_cell_code,
  input  logic [9:0]  in_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit_found,
  output logic        out_hit_side,
  output logic [5:0]  out_hit_cell_x,
  output logic [5:0]  out_hit_cell_y,
  output logic [23:0] out_wall_distance,
  output logic [15:0] out_slice_height,
  output logic [9:0]  out_start_row,
  output logic [9:0]  out_end_row,
  output logic [15:0] out_texture_fraction,
  output logic [9:0]  out_echo_column,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import dgr_pkg::*;
  `include "dda_grid_raycaster_top_assert.svh"

  localparam int MB = $clog2(MAP_SIDE);
  localparam int AW = 2 * MB;
  localparam int SB = $clog2(MAX_STEPS + 1);
  localparam logic [2:0] REG_POS_X = 3'd0, REG_POS_Y = 3'd1, REG_DIR_X = 3'd2,
    REG_DIR_Y = 3'd3, REG_PLANE_X = 3'd4, REG_PLANE_Y = 3'd5;
  localparam logic [9:0] HALF_H = 10'(SCREEN_HEIGHT / 2);
  localparam logic [15:0] HALF_H16 = 16'(SCREEN_HEIGHT / 2);
  localparam logic [9:0] LAST_ROW = 10'(SCREEN_HEIGHT - 1);
  localparam logic [33:0] HEIGHT_Q = 34'(longint'(SCREEN_HEIGHT) << 16);
  // ceil(2^41 / W): exact floor(c * 2^17 / W) for every c below W
  localparam logic [40:0] CAM_RECIP =
    41'(((longint'(1) << 41) + longint'(SCREEN_WIDTH) - 1) / longint'(SCREEN_WIDTH));

  logic [21:0] pos_x_r, pos_y_r;
  logic signed [17:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;

  state_t state_r, state_nxt;
  logic signed [19:0] rdx_r, rdy_r;
  logic [23:0] dx_r, dy_r, sx_r, sy_r;
  logic signed [9:0] mx_r, my_r;
  logic side_r, hit_r;
  logic [SB-1:0] steps_r;
  logic [9:0] col_r;
  logic signed [18:0] cam_r;
  logic [23:0] wd_r;
  logic [15:0] lh_r;
  logic [15:0] tf_r;
  logic out_valid_r;

  // shared divider
  logic div_start;
  logic [33:0] div_dividend, div_q;
  logic [23:0] div_divisor;
  logic div_busy;
  logic div_go_r;
  dgr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .busy(div_busy), .quotient(div_q)
  );

  // map
  logic map_we;
  logic [AW-1:0] map_waddr, map_raddr;
  logic [7:0] map_rdata;
  dgr_ram #(.WIDTH(8), .DEPTH(MAP_SIDE * MAP_SIDE)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(in_cell_code),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  logic in_acc;
  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;
  assign in_acc = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign map_we = in_acc && (in_command == CMD_WRITE) &&
                  ({2'b0, in_cell_x} < 8'(MAP_SIDE)) && ({2'b0, in_cell_y} < 8'(MAP_SIDE));
  assign map_waddr = {in_cell_y[MB-1:0], in_cell_x[MB-1:0]};
  assign map_raddr = {my_r[MB-1:0], mx_r[MB-1:0]};

  // camera coordinate: floor(2*c*65536/W) - 65536, by reciprocal multiply
  logic [11:0] col_c;
  logic [52:0] cam_prod;
  logic signed [18:0] cam_c;
  always_comb begin
    col_c = ({3'b0, in_column} >= 13'(SCREEN_WIDTH)) ? 12'(SCREEN_WIDTH - 1)
                                                       : {2'b0, in_column};
    cam_prod = 53'(col_c) * 53'(CAM_RECIP);
    cam_c = $signed({1'b0, cam_prod[41:24]}) - 19'sd65536;
  end

  // ray component: dir + floor(plane*cam/65536) (arithmetic shift is floor)
  logic signed [36:0] px_prod, py_prod;
  assign px_prod = 37'(plane_x_r) * 37'(cam_r);
  assign py_prod = 37'(plane_y_r) * 37'(cam_r);

  logic [19:0] abs_rx, abs_ry;
  assign abs_rx = rdx_r[19] ? 20'(-rdx_r) : 20'(rdx_r);
  assign abs_ry = rdy_r[19] ? 20'(-rdy_r) : 20'(rdy_r);

  // side distances start
  logic [15:0] fx, fy;
  logic [16:0] fmx, fmy;
  logic [40:0] sx_p, sy_p;
  always_comb begin
    fx = pos_x_r[15:0];
    fy = pos_y_r[15:0];
    fmx = rdx_r[19] ? {1'b0, fx} : 17'h10000 - {1'b0, fx};
    fmy = rdy_r[19] ? {1'b0, fy} : 17'h10000 - {1'b0, fy};
    sx_p = 41'(fmx) * 41'(dx_r);
    sy_p = 41'(fmy) * 41'(dy_r);
  end

  logic out_map;
  assign out_map = mx_r < 0 || my_r < 0 ||
                   mx_r >= 10'sd0 + 10'(MAP_SIDE) || my_r >= 10'sd0 + 10'(MAP_SIDE);

  // texture: (base<<16 + wd*r) >> 16 low 16 bits
  logic [21:0] tbase;
  logic signed [19:0] tr;
  logic signed [45:0] tprod;
  logic [15:0] tf_c;
  always_comb begin
    tbase = side_r ? pos_x_r : pos_y_r;
    tr = side_r ? rdx_r : rdy_r;
    tprod = 46'($signed({1'b0, wd_r})) * 46'(tr);
    tf_c = 16'(tprod[31:16] + tbase[15:0]);
  end

  logic [15:0] lh_sat;
  assign lh_sat = (div_q > 34'(HEIGHT_MAX)) ? HEIGHT_MAX : div_q[15:0];

  // upper bits of the side distances: sums grow past 24 bits over a long walk
  logic [7:0] sxo_r, syo_r;

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_dividend = 34'h100000000;
    div_divisor = 24'(abs_rx);
    unique case (state_r)
      ST_IDLE: if (in_acc && in_command == CMD_CAST) state_nxt = ST_RAY;
      ST_RAY:  state_nxt = ST_DIVX;
      ST_DIVX: begin
        div_divisor = 24'(abs_rx);
        div_start = !div_go_r;
        if (div_go_r && !div_busy) state_nxt = ST_DIVY;
      end
      ST_DIVY: begin
        div_divisor = 24'(abs_ry);
        div_start = !div_go_r;
        if (div_go_r && !div_busy) state_nxt = ST_SIDE;
      end
      ST_SIDE: state_nxt = ST_STEP;
      ST_STEP: state_nxt = ST_READ;
      ST_READ: state_nxt = out_map ? ST_FIN : ST_TEST;
      ST_TEST: begin
        if (map_rdata == CODE_WALL || map_rdata == CODE_DOOR) state_nxt = ST_LDIV;
        else if (32'(steps_r) >= 32'(MAX_STEPS)) state_nxt = ST_FIN;
        else state_nxt = ST_STEP;
      end
      ST_LDIV: begin
        div_dividend = HEIGHT_Q;
        div_divisor = wd_r;
        div_start = !div_go_r && (wd_r != 24'd0);
        if (wd_r == 24'd0 || (div_go_r && !div_busy)) state_nxt = ST_FIN;
      end
      ST_FIN: state_nxt = ST_OUT;
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      div_go_r <= 1'b0;
      pos_x_r <= '0;
      pos_y_r <= '0;
      dir_x_r <= 18'sd65536;
      dir_y_r <= '0;
      plane_x_r <= '0;
      plane_y_r <= 18'sd43253;
    end else begin
      state_r <= state_nxt;
      div_go_r <= (state_nxt == state_r) && (div_start || div_go_r);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_POS_X:   pos_x_r <= cfg_data[21:0];
          REG_POS_Y:   pos_y_r <= cfg_data[21:0];
          REG_DIR_X:   dir_x_r <= cfg_data[17:0];
          REG_DIR_Y:   dir_y_r <= cfg_data[17:0];
          REG_PLANE_X: plane_x_r <= cfg_data[17:0];
          REG_PLANE_Y: plane_y_r <= cfg_data[17:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == ST_OUT) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        col_r <= in_column;
        cam_r <= cam_c;
        steps_r <= '0;
        hit_r <= 1'b0;
        side_r <= 1'b0;
      end
      ST_RAY: begin
        rdx_r <= 20'(dir_x_r) + 20'(px_prod >>> 16);
        rdy_r <= 20'(dir_y_r) + 20'(py_prod >>> 16);
        mx_r <= 10'(pos_x_r[21:16]);
        my_r <= 10'(pos_y_r[21:16]);
      end
      ST_DIVX: if (div_go_r && !div_busy)
        dx_r <= (abs_rx == 20'd0 || div_q > 34'(DIST_MAX)) ? DIST_MAX : div_q[23:0];
      ST_DIVY: if (div_go_r && !div_busy)
        dy_r <= (abs_ry == 20'd0 || div_q > 34'(DIST_MAX)) ? DIST_MAX : div_q[23:0];
      ST_SIDE: begin
        sx_r <= sx_p[39:16];
        sy_r <= sy_p[39:16];
        sxo_r <= {7'b0, sx_p[40]};
        syo_r <= {7'b0, sy_p[40]};
      end
      ST_STEP: begin
        steps_r <= steps_r + 1'b1;
        if ({sxo_r, sx_r} < {syo_r, sy_r}) begin
          {sxo_r, sx_r} <= {sxo_r, sx_r} + {8'b0, dx_r};
          mx_r <= rdx_r[19] ? mx_r - 10'sd1 : mx_r + 10'sd1;
          side_r <= 1'b0;
          wd_r <= (sxo_r != 8'd0) ? DIST_MAX : sx_r;
        end else begin
          {syo_r, sy_r} <= {syo_r, sy_r} + {8'b0, dy_r};
          my_r <= rdy_r[19] ? my_r - 10'sd1 : my_r + 10'sd1;
          side_r <= 1'b1;
          wd_r <= (syo_r != 8'd0) ? DIST_MAX : sy_r;
        end
      end
      ST_TEST: if (map_rdata == CODE_WALL || map_rdata == CODE_DOOR) hit_r <= 1'b1;
      ST_LDIV: if (wd_r == 24'd0) lh_r <= HEIGHT_MAX;
               else if (div_go_r && !div_busy) lh_r <= lh_sat;
      ST_FIN: tf_r <= tf_c;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT) begin
      out_hit_found <= hit_r;
      out_echo_column <= col_r;
      out_hit_side <= hit_r & side_r;
      out_hit_cell_x <= hit_r ? mx_r[5:0] : 6'd0;
      out_hit_cell_y <= hit_r ? my_r[5:0] : 6'd0;
      out_wall_distance <= hit_r ? wd_r : 24'd0;
      out_slice_height <= hit_r ? lh_r : 16'd0;
      out_texture_fraction <= hit_r ? tf_r : 16'd0;
      out_start_row <= !hit_r ? 10'd0 :
        ({1'b0, lh_r[15:1]} >= HALF_H16) ? 10'd0 : 10'(HALF_H16 - {1'b0, lh_r[15:1]});
      out_end_row <= !hit_r ? 10'd0 :
        (16'({1'b0, lh_r[15:1]}) + HALF_H16 >= 16'(SCREEN_HEIGHT)) ? LAST_ROW :
        10'(lh_r[15:1]) + HALF_H;
    end
  end
  assign out_valid = out_valid_r;

  logic unused_ok;
  assign unused_ok = ^cfg_data[31:22];

  `DGR_ASSERT_IMPL(a_busy_not_ready, state_r != ST_IDLE, !in_ready)
  `DGR_ASSERT_NEXT(a_out_follows, state_r == ST_OUT, out_valid)
  `DGR_ASSERT_IMPL(a_no_write_in_walk, state_r != ST_IDLE, !map_we)
endmodule
